// File: rtl/core/cdod_pkg.sv
package cdod_pkg;

	localparam int MAX_BINS     = 512;
	localparam int BIN_W        = $clog2(MAX_BINS);
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int CW           = 36;
	localparam int ZW           = 34;
	localparam int NB_W         = 10;
	localparam int SQRT_STEPS   = 32;
	localparam int SQ_CNT_W     = $clog2(SQRT_STEPS);

	localparam logic signed [ZW-1:0] PI_ANGLE      = 34'sd2147483648;
	localparam logic signed [ZW-1:0] HALF_PI_ANGLE = 34'sd1073741824;
	localparam logic signed [CW-1:0] CORDIC_GAIN   = 36'sd652032874;
	localparam logic [33:0]          ONSET_MAX     = 34'h3_FFFF_FFFF;
	localparam logic [43:0]          SUM_MAX       = 44'hFFF_FFFF_FFFF;

	typedef struct packed {
		logic [8:0]         bin_index;
		logic signed [15:0] bin_re;
		logic signed [15:0] bin_im;
	} cdod_in_t;

	typedef struct packed {
		logic [33:0] bin_onset;
		logic [43:0] frame_sum;
		logic        frame_done;
	} cdod_out_t;

	typedef struct packed {
		logic [31:0] mag_sq;
		logic [15:0] phase;
		logic [15:0] pphase;
	} hist_t;

	typedef enum logic {
		CORDIC_VECTOR,
		CORDIC_ROTATE
	} cordic_mode_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAG_RE,
		ST_MAG_IM,
		ST_VEC_GO,
		ST_VEC_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_ROT_GO,
		ST_ROT_WAIT,
		ST_FINISH,
		ST_OOR
	} state_t;

	// atan(2^-i), pi = 2^31
	function automatic logic signed [ZW-1:0] atan_angle(input logic [4:0] i);
		logic signed [ZW-1:0] a;
		case (i)
			5'd0:  a = 34'sh20000000;
			5'd1:  a = 34'sh12E4051E;
			5'd2:  a = 34'sh09FB385B;
			5'd3:  a = 34'sh051111D4;
			5'd4:  a = 34'sh028B0D43;
			5'd5:  a = 34'sh0145D7E1;
			5'd6:  a = 34'sh00A2F61E;
			5'd7:  a = 34'sh00517C55;
			5'd8:  a = 34'sh0028BE53;
			5'd9:  a = 34'sh00145F2F;
			5'd10: a = 34'sh000A2F98;
			5'd11: a = 34'sh000517CC;
			5'd12: a = 34'sh00028BE6;
			5'd13: a = 34'sh000145F3;
			5'd14: a = 34'sh0000A2F9;
			5'd15: a = 34'sh0000517C;
			5'd16: a = 34'sh000028BE;
			5'd17: a = 34'sh0000145F;
			5'd18: a = 34'sh00000A2F;
			5'd19: a = 34'sh00000517;
			5'd20: a = 34'sh0000028B;
			5'd21: a = 34'sh00000145;
			5'd22: a = 34'sh000000A2;
			5'd23: a = 34'sh00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: rtl/core/cdod_cordic.sv
module cdod_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cdod_pkg::cordic_ctl_t                  ctl,
	input  logic signed [cdod_pkg::CW-1:0]         x_init,
	input  logic signed [cdod_pkg::CW-1:0]         y_init,
	input  logic signed [cdod_pkg::ZW-1:0]         z_init,
	output logic                                   done,
	output logic signed [cdod_pkg::CW-1:0]         x_out,
	output logic signed [cdod_pkg::ZW-1:0]         z_out
);
	import cdod_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	cordic_mode_t         mode_q;
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] ang;
	logic                 ccw;

	assign xs  = x_q >>> step_q;
	assign ys  = y_q >>> step_q;
	assign ang = atan_angle(5'(step_q));
	// Vectoring drives y toward zero, rotation drives z toward zero.
	assign ccw = (mode_q == CORDIC_VECTOR) ? y_q[CW-1] : !z_q[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q    <= x_init;
			y_q    <= y_init;
			z_q    <= z_init;
			mode_q <= ctl.mode;
		end else if (busy_q) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign z_out = z_q;

endmodule

// File: rtl/core/cdod_isqrt.sv
module cdod_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	output logic        done,
	output logic [31:0] root
);
	import cdod_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic [63:0]         num_q;
	logic [63:0]         res_q;
	logic [63:0]         bit_q;
	logic [63:0]         trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == SQ_CNT_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One result bit per cycle, starting from the top digit pair.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (num_q >= trial) begin
				num_q <= num_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// File: rtl/core/cdod_hist.sv
module cdod_hist (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [cdod_pkg::BIN_W-1:0]   rd_addr,
	output cdod_pkg::hist_t              rd_data,
	input  logic                         wr_en,
	input  logic [cdod_pkg::BIN_W-1:0]   wr_addr,
	input  cdod_pkg::hist_t              wr_data,
	output logic                         clearing
);
	import cdod_pkg::*;

	hist_t            mem [MAX_BINS];
	hist_t            rd_data_q;
	logic             clearing_q;
	logic [BIN_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BIN_W'(MAX_BINS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// File: rtl/core/complex_domain_onset_detector_core.sv
// Steps for a bin in range: 16 CORDIC vectoring steps, 32 square root steps, 16 CORDIC
// rotation steps and the control states between them; a zero bin skips vectoring, and a bin
// out of range goes straight to the output. A new bin is taken only once the last one has
// been handed to the output register, which waits while out_stall holds it.
// Reset: asynchronous, active low; the bins-per-frame register returns to 512, the sum to zero,
// and a clearing pass zeroes all 512 entries of the bin history, with no bin taken meanwhile.
module complex_domain_onset_detector_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  cdod_pkg::cdod_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output cdod_pkg::cdod_out_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cdod_pkg::NB_W-1:0]     cfg_data
);
	import cdod_pkg::*;

	state_t               state_q;
	state_t               state_d;
	logic [NB_W-1:0]      bins_per_frame_q;
	logic [NB_W-1:0]      limit;
	logic                 accept;
	logic                 in_range;
	logic                 out_free;
	logic                 clearing;

	logic [BIN_W-1:0]     idx_q;
	logic signed [15:0]   re_q;
	logic signed [15:0]   im_q;
	logic [31:0]          a_q;
	hist_t                hist_q;
	hist_t                rd_data;
	logic [15:0]          phase_q;
	logic [31:0]          g_q;
	logic [43:0]          accum_q;
	logic signed [65:0]   prod_q;
	logic signed [32:0]   mul_a;
	logic signed [32:0]   mul_b;
	logic signed [65:0]   prod;

	cordic_ctl_t          cctl;
	logic signed [CW-1:0] cx_init;
	logic signed [CW-1:0] cy_init;
	logic signed [ZW-1:0] cz_init;
	logic                 cdone;
	logic signed [CW-1:0] cx_out;
	logic signed [ZW-1:0] cz_out;
	logic                 sq_start;
	logic                 sq_done;
	logic [31:0]          sq_root;

	logic [15:0]          dev;
	logic signed [ZW-1:0] z_dev;
	logic signed [CW-1:0] x_vec;
	logic [31:0]          z_round;
	logic signed [66:0]   term_full;
	logic signed [36:0]   term;
	logic signed [39:0]   val;
	logic [33:0]          onset;
	logic [43:0]          base;
	logic [44:0]          sum_w;
	logic [43:0]          sum;
	logic                 last_bin;
	logic                 zero_bin;
	logic                 hist_we;
	hist_t                hist_wd;
	logic                 vec_z_src;

	assign limit     = (bins_per_frame_q > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : bins_per_frame_q;
	assign in_range  = (NB_W'(in_data.bin_index) < limit);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;
	assign zero_bin  = (re_q == '0) && (im_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_per_frame_q <= NB_W'(MAX_BINS);
		end else if (cfg_valid && cfg_ready) begin
			bins_per_frame_q <= cfg_data;
		end
	end

	// Shared multiplier: re*re, im*im, a*b and g*cos in turn.
	always_comb begin
		case (state_q)
			ST_MAG_RE: begin
				mul_a = 33'(re_q);
				mul_b = 33'(re_q);
			end
			ST_MAG_IM: begin
				mul_a = 33'(im_q);
				mul_b = 33'(im_q);
			end
			ST_VEC_GO: begin
				mul_a = $signed({1'b0, a_q});
				mul_b = $signed({1'b0, hist_q.mag_sq});
			end
			default: begin
				mul_a = $signed({1'b0, g_q});
				mul_b = 33'(cx_out);
			end
		endcase
		prod = mul_a * mul_b;
	end

	// CORDIC start values.
	assign dev       = phase_q - {hist_q.phase[14:0], 1'b0} + hist_q.pphase;
	assign z_dev     = ZW'($signed({dev, 16'h0000}));
	assign x_vec     = CW'(re_q) <<< 14;
	assign vec_z_src = re_q[15];

	always_comb begin
		cctl.start = 1'b0;
		cctl.mode  = CORDIC_VECTOR;
		cx_init    = '0;
		cy_init    = '0;
		cz_init    = '0;
		if (state_q == ST_VEC_GO) begin
			cctl.start = !zero_bin;
			if (vec_z_src) begin
				cx_init = -x_vec;
				cy_init = -(CW'(im_q) <<< 14);
				cz_init = PI_ANGLE;
			end else begin
				cx_init = x_vec;
				cy_init = CW'(im_q) <<< 14;
			end
		end else if (state_q == ST_ROT_GO) begin
			cctl.start = 1'b1;
			cctl.mode  = CORDIC_ROTATE;
			if (z_dev > HALF_PI_ANGLE) begin
				cz_init = z_dev - PI_ANGLE;
				cx_init = -CORDIC_GAIN;
			end else if (z_dev < -HALF_PI_ANGLE) begin
				cz_init = z_dev + PI_ANGLE;
				cx_init = -CORDIC_GAIN;
			end else begin
				cz_init = z_dev;
				cx_init = CORDIC_GAIN;
			end
		end
	end

	assign sq_start = (state_q == ST_SQRT_GO);
	assign z_round  = cz_out[31:0] + 32'h0000_8000;

	// Final combination of the deviation and the frame sum.
	assign term_full = $signed({prod_q, 1'b0}) + 67'sd536870912;
	assign term      = 37'(term_full >>> 30);
	assign val       = $signed({8'h00, a_q}) + $signed({8'h00, hist_q.mag_sq}) - 40'(term);
	always_comb begin
		if (val[39]) begin
			onset = '0;
		end else if (val > $signed({6'b0, ONSET_MAX})) begin
			onset = ONSET_MAX;
		end else begin
			onset = val[33:0];
		end
	end
	assign base     = (idx_q == '0) ? '0 : accum_q;
	assign sum_w    = {1'b0, base} + 45'(onset);
	assign sum      = sum_w[44] ? SUM_MAX : sum_w[43:0];
	assign last_bin = (NB_W'(idx_q) == limit - 1'b1);

	assign hist_we = (state_q == ST_FINISH) && out_free;
	assign hist_wd = '{mag_sq: a_q, phase: phase_q, pphase: hist_q.phase};

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = clearing;
				if (in_valid && !clearing) begin
					state_d = in_range ? ST_MAG_RE : ST_OOR;
				end
			end
			ST_MAG_RE:    state_d = ST_MAG_IM;
			ST_MAG_IM:    state_d = ST_VEC_GO;
			ST_VEC_GO:    state_d = zero_bin ? ST_SQRT_GO : ST_VEC_WAIT;
			ST_VEC_WAIT:  state_d = cdone ? ST_SQRT_GO : ST_VEC_WAIT;
			ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: state_d = sq_done ? ST_ROT_GO : ST_SQRT_WAIT;
			ST_ROT_GO:    state_d = ST_ROT_WAIT;
			ST_ROT_WAIT:  state_d = cdone ? ST_FINISH : ST_ROT_WAIT;
			ST_FINISH:    state_d = out_free ? ST_IDLE : ST_FINISH;
			ST_OOR:       state_d = out_free ? ST_IDLE : ST_OOR;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			accum_q   <= '0;
		end else begin
			if (out_free && (state_q == ST_FINISH || state_q == ST_OOR)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (hist_we) begin
				accum_q <= last_bin ? '0 : sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= in_data.bin_index;
			re_q  <= in_data.bin_re;
			im_q  <= in_data.bin_im;
		end
		case (state_q)
			ST_MAG_RE: begin
				prod_q <= prod;
				hist_q <= rd_data;
			end
			ST_MAG_IM: begin
				a_q <= prod_q[31:0] + prod[31:0];
			end
			ST_VEC_GO: begin
				prod_q <= prod;
				if (zero_bin) begin
					phase_q <= '0;
				end
			end
			ST_VEC_WAIT: begin
				if (cdone) begin
					phase_q <= z_round[31:16];
				end
			end
			ST_SQRT_WAIT: begin
				if (sq_done) begin
					g_q <= sq_root;
				end
			end
			ST_ROT_WAIT: begin
				if (cdone) begin
					prod_q <= prod;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_data.bin_onset  <= onset;
					out_data.frame_sum  <= sum;
					out_data.frame_done <= last_bin;
				end
			end
			ST_OOR: begin
				if (out_free) begin
					out_data.bin_onset  <= '0;
					out_data.frame_sum  <= accum_q;
					out_data.frame_done <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	cdod_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x_init (cx_init),
		.y_init (cy_init),
		.z_init (cz_init),
		.done   (cdone),
		.x_out  (cx_out),
		.z_out  (cz_out)
	);

	cdod_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.num    (prod_q[63:0]),
		.done   (sq_done),
		.root   (sq_root)
	);

	cdod_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_data.bin_index),
		.rd_data  (rd_data),
		.wr_en    (hist_we),
		.wr_addr  (idx_q),
		.wr_data  (hist_wd),
		.clearing (clearing)
	);

endmodule

// File: test/complex_domain_onset_detector_core_checker.sv
`timescale 1ns / 100ps
module complex_domain_onset_detector_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  cdod_pkg::cdod_in_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  cdod_pkg::cdod_out_t           out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [cdod_pkg::NB_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending_count
);
	import cdod_pkg::*;

	logic [31:0] hist_mag [MAX_BINS];
	logic [15:0] hist_ph [MAX_BINS];
	logic [15:0] hist_pph [MAX_BINS];
	logic [43:0] running_sum;
	logic [9:0]  band_count;
	cdod_out_t   expected_bins [$];

	localparam longint TAN_TABLE [16] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C
	};

	assign pending_count = expected_bins.size();

	function automatic logic [15:0] bin_phase(longint re, longint im);
		longint x, y, z, xs, ys;
		logic [31:0] zl;
		x = re * 16384;
		y = im * 16384;
		z = 0;
		if (re == 0 && im == 0)
			return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 64'sd2147483648;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += TAN_TABLE[i];
			end else begin
				x -= ys; y += xs; z -= TAN_TABLE[i];
			end
		end
		zl = z[31:0] + 32'h8000;
		return zl[31:16];
	endfunction

	function automatic longint deviation_cos(logic [15:0] ang);
		longint z, x, y, xs, ys;
		z = longint'(signed'({ang, 16'h0}));
		x = 652032874;
		y = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			x = -x;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			x = -x;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= TAN_TABLE[i];
			end else begin
				x += ys; y -= xs; z += TAN_TABLE[i];
			end
		end
		return x;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned num);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > num)
			bitv >>= 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic cdod_out_t predict_bin(cdod_in_t item);
		cdod_out_t r;
		int unsigned lim, idx;
		longint re, im, a, b, term, val;
		longint unsigned g, sum;
		logic [15:0] ph, dev;
		lim = (band_count > 512) ? 512 : band_count;
		idx = item.bin_index;
		re = item.bin_re;
		im = item.bin_im;
		r = '0;
		if (idx >= lim) begin
			r.frame_sum = running_sum;
			return r;
		end
		a = re * re + im * im;
		b = hist_mag[idx];
		ph = bin_phase(re, im);
		dev = ph - 16'(2 * hist_ph[idx]) + hist_pph[idx];
		g = floor_sqrt(longint'(a) * longint'(b));
		term = (longint'(2 * g) * deviation_cos(dev) + (64'sd1 << 29)) >>> 30;
		val = a + b - term;
		if (val < 0)
			val = 0;
		if (val > longint'(ONSET_MAX))
			val = longint'(ONSET_MAX);
		hist_mag[idx] = a[31:0];
		hist_pph[idx] = hist_ph[idx];
		hist_ph[idx] = ph;
		sum = ((idx == 0) ? 0 : running_sum) + val;
		if (sum > SUM_MAX)
			sum = SUM_MAX;
		r.bin_onset = val[33:0];
		r.frame_sum = sum[43:0];
		r.frame_done = (idx == lim - 1);
		running_sum = r.frame_done ? '0 : sum[43:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		running_sum = '0;
		band_count = 10'd512;
		for (int i = 0; i < MAX_BINS; i++) begin
			hist_mag[i] = '0;
			hist_ph[i] = '0;
			hist_pph[i] = '0;
		end
	end

	always @(posedge clk) begin
		cdod_out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				band_count = cfg_data;
			if (in_valid && !in_stall)
				expected_bins.push_back(predict_bin(in_data));
			if (out_valid && !out_stall) begin
				if (expected_bins.size() == 0) begin
					report_mismatch("unexpected transaction", 0, 0);
				end else begin
					want = expected_bins.pop_front();
					if (out_data.bin_onset !== want.bin_onset)
						report_mismatch("bin_onset", out_data.bin_onset, want.bin_onset);
					if (out_data.frame_sum !== want.frame_sum)
						report_mismatch("frame_sum", out_data.frame_sum, want.frame_sum);
					if (out_data.frame_done !== want.frame_done)
						report_mismatch("frame_done", out_data.frame_done, want.frame_done);
				end
			end
		end
	end

endmodule

// File: test/complex_domain_onset_detector_core_test.sv
`timescale 1ns / 100ps
module complex_domain_onset_detector_core_test;
	import cdod_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	cdod_in_t          in_data;
	logic              out_valid;
	logic              out_stall;
	cdod_out_t         out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [NB_W-1:0]   cfg_data;
	int                fail_count;
	int                pending_count;
	int                hold_cycles;
	bit                stall_storm;

	complex_domain_onset_detector_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	complex_domain_onset_detector_core_checker checker_0 (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver stall pattern; one long hold-off fills the block up.
	initial begin
		out_stall = 1'b0;
		stall_storm = 1'b0;
		hold_cycles = 0;
		forever begin
			@(negedge clk);
			if (stall_storm) begin
				out_stall <= 1'b1;
				hold_cycles++;
				if (hold_cycles >= 400) begin
					stall_storm = 1'b0;
					hold_cycles = 0;
				end
			end else begin
				case ($urandom_range(0, 3))
					0: out_stall <= ($urandom_range(0, 9) < 8);
					1: out_stall <= 1'b0;
					default: out_stall <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic write_bands(logic [NB_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_bin(logic [8:0] idx, logic [15:0] re, logic [15:0] im);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{bin_index: idx, bin_re: re, bin_im: im};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_block;
		idle_gap(0);
		while (pending_count != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [15:0] random_part();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 255)) - 16'd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random frames in ascending bin order, with random bin indices as noise.
	task automatic random_frames(int bands, int items);
		int n, burst;
		n = 0;
		burst = $urandom_range(1, 12);
		while (n < items) begin
			for (int b = 0; b < bands && n < items; b++) begin
				if ($urandom_range(0, 19) == 0)
					send_bin(9'($urandom_range(0, 511)), random_part(), random_part());
				else
					send_bin(9'(b), random_part(), random_part());
				n++;
				if (--burst == 0) begin
					idle_gap($urandom_range(0, 30));
					burst = $urandom_range(1, 12);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme parts, zero bins, out-of-range bins and frame ends at 512.
		send_bin(9'd0, 16'h7FFF, 16'h7FFF);
		send_bin(9'd1, 16'h8000, 16'h8000);
		send_bin(9'd2, 16'h0000, 16'h0000);
		send_bin(9'd3, 16'h8000, 16'h0000);
		send_bin(9'd4, 16'h0000, 16'h7FFF);
		send_bin(9'd511, 16'h8000, 16'h7FFF);
		send_bin(9'd0, 16'hFFFF, 16'h0001);
		send_bin(9'd0, 16'h0001, 16'hFFFF);
		send_bin(9'd1, 16'h8000, 16'h8000);
		drain_block();
		write_bands(10'd4);
		for (int f = 0; f < 3; f++)
			for (int b = 0; b < 5; b++)
				send_bin(9'(b), (f[0] ? 16'h8000 : 16'h7FFF), 16'(b * 9000));
		send_bin(9'd3, 16'h7FFF, 16'h8000);
		drain_block();
		write_bands(10'd0);
		send_bin(9'd0, 16'h1234, 16'h4321);
		send_bin(9'd511, 16'hFFFF, 16'hFFFF);
		drain_block();
		write_bands(10'd1);
		random_frames(2, 150);
		drain_block();
		write_bands(10'd1023);
		send_bin(9'd511, 16'h7FFF, 16'h7FFF);
		drain_block();
		write_bands(10'd8);
		stall_storm = 1'b1;
		random_frames(9, 450);
		drain_block();
		write_bands(10'd512);
		random_frames(512, 90);
		drain_block();
		write_bands(10'($urandom_range(2, 40)));
		random_frames(41, 450);
		drain_block();

		if (fail_count == 0)
			$display("complex_domain_onset_detector_core_test: PASS");
		else
			$display("complex_domain_onset_detector_core_test: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("complex_domain_onset_detector_core_test: FAIL");
		$finish;
	end

endmodule

// File: complex_domain_onset_detector_core.f
rtl/core/cdod_pkg.sv
rtl/core/cdod_cordic.sv
rtl/core/cdod_isqrt.sv
rtl/core/cdod_hist.sv
rtl/core/complex_domain_onset_detector_core.sv
test/complex_domain_onset_detector_core_checker.sv
test/complex_domain_onset_detector_core_test.sv
